@@ sv/cgmdp_pkg.sv @@
// Package with the shared types, constants and arithmetic helpers of the dot-product block.
`default_nettype none

package cgmdp_pkg;

  // Field widths.
  localparam int ELEM_W     = 32;
  localparam int SUM_W      = 64;
  localparam int WIDE_W     = SUM_W + 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register word index of the mode register.
  localparam logic REG_MODE = 1'b0;

  // Saturation limits of a Q32.32 accumulator.
  localparam logic [SUM_W-1:0] SAT_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SAT_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // One input element held in the input register.
  typedef struct packed {
    logic             mode;
    logic             last;
    logic [2:0][ELEM_W-1:0] d;
    logic [2:0][ELEM_W-1:0] q;
    logic [2:0][ELEM_W-1:0] r;
  } in_item_t;

  // Component products of one element, handed to the accumulator stage.
  typedef struct packed {
    logic                  mode;
    logic                  last;
    logic [2:0][SUM_W-1:0] dq;
    logic [2:0][SUM_W-1:0] rq;
    logic [2:0][SUM_W-1:0] qq;
  } prod_t;

  // Exact Q16.16 times Q16.16 product as a Q32.32 pattern.
  function automatic sum_t mul32(input logic signed [ELEM_W-1:0] a,
                                 input logic signed [ELEM_W-1:0] b);
    logic signed [SUM_W-1:0] p;
    p = a * b;
    return sum_t'(p);
  endfunction

  // Accumulator plus three products, formed exactly and then clamped.
  function automatic sum_t add_sat(input sum_t acc, input sum_t p0,
                                   input sum_t p1, input sum_t p2);
    logic [WIDE_W-1:0] s;
    s = {{2{acc[SUM_W-1]}}, acc} + {{2{p0[SUM_W-1]}}, p0}
      + {{2{p1[SUM_W-1]}}, p1} + {{2{p2[SUM_W-1]}}, p2};
    if (s[WIDE_W-1:SUM_W-1] == 3'b000 || s[WIDE_W-1:SUM_W-1] == 3'b111) begin
      return s[SUM_W-1:0];
    end
    return s[WIDE_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

endpackage

`default_nettype wire

@@ sv/cgmdp_if.sv @@
// Stream interfaces for the element input channel and the result channel.
`default_nettype none

interface cgmdp_in_if;
  import cgmdp_pkg::*;
  logic  valid;
  logic  ready;
  elem_t d_x;
  elem_t d_y;
  elem_t d_z;
  elem_t q_x;
  elem_t q_y;
  elem_t q_z;
  elem_t r_x;
  elem_t r_y;
  elem_t r_z;
  logic  last;

  modport source (output valid, d_x, d_y, d_z, q_x, q_y, q_z, r_x, r_y, r_z, last,
                  input ready);
  modport sink (input valid, d_x, d_y, d_z, q_x, q_y, q_z, r_x, r_y, r_z, last,
                output ready);
endinterface

interface cgmdp_out_if;
  import cgmdp_pkg::*;
  logic valid;
  logic ready;
  sum_t first_sum;
  sum_t second_sum;
  sum_t third_sum;

  modport source (output valid, first_sum, second_sum, third_sum, input ready);
  modport sink (input valid, first_sum, second_sum, third_sum, output ready);
endinterface

`default_nettype wire

@@ sv/cgmdp_cfg.sv @@
// APB-style register file holding the mode register.
`default_nettype none

module cgmdp_cfg
  import cgmdp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output logic                       mode
);

  logic mode_r;
  logic hit_mode;
  logic wr_en;

  // Address decode on the word index; byte offsets are ignored.
  assign hit_mode   = (cfg_paddr[CFG_ADDR_W-1:2] == REG_MODE);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Mode register write in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (wr_en && hit_mode) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  // Read back.
  assign cfg_prdata = hit_mode ? {{(CFG_DATA_W-1){1'b0}}, mode_r} : '0;
  assign mode       = mode_r;

endmodule

`default_nettype wire

@@ sv/cgmdp_prod.sv @@
// Input register and component-product register of the dot-product pipeline.
`default_nettype none

module cgmdp_prod
  import cgmdp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   mode,
  cgmdp_in_if.sink    in_ch,
  output logic        prod_valid,
  output prod_t       prod_data,
  input  wire logic   prod_ready
);

  logic     v1_r;
  logic     v2_r;
  in_item_t item_r;
  prod_t    prod_r;
  prod_t    prod_nxt;
  logic     ready1;
  logic     ready2;

  // Each stage moves on when the next one is empty or moving.
  assign ready2      = !v2_r || prod_ready;
  assign ready1      = !v1_r || ready2;
  assign in_ch.ready = ready1;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_ch.valid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
    end
  end

  // Capture the element together with the mode in force at acceptance.
  always_ff @(posedge clk) begin
    if (in_ch.valid && ready1) begin
      item_r.mode <= mode;
      item_r.last <= in_ch.last;
      item_r.d    <= {in_ch.d_z, in_ch.d_y, in_ch.d_x};
      item_r.q    <= {in_ch.q_z, in_ch.q_y, in_ch.q_x};
      item_r.r    <= {in_ch.r_z, in_ch.r_y, in_ch.r_x};
    end
  end

  // Nine independent component products.
  always_comb begin
    prod_nxt.mode = item_r.mode;
    prod_nxt.last = item_r.last;
    for (int i = 0; i < 3; i++) begin
      prod_nxt.dq[i] = mul32(item_r.d[i], item_r.q[i]);
      prod_nxt.rq[i] = mul32(item_r.r[i], item_r.q[i]);
      prod_nxt.qq[i] = mul32(item_r.q[i], item_r.q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && ready2) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_valid = v2_r;
  assign prod_data  = prod_r;

  // A product word that is not taken stays in its stage.
  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !prod_ready |=> v2_r && $stable(prod_r))
    else $error("product stage lost a transaction while stalled");

endmodule

`default_nettype wire

@@ sv/cgmdp_acc.sv @@
// Saturating accumulators and result register of the dot-product block.
`default_nettype none

module cgmdp_acc
  import cgmdp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   prod_valid,
  input  prod_t       prod_data,
  output logic        prod_ready,
  cgmdp_out_if.source out_ch
);

  sum_t acc_dq_r;
  sum_t acc_rq_r;
  sum_t acc_qq_r;
  sum_t dq_nxt;
  sum_t rq_nxt;
  sum_t qq_nxt;
  logic out_valid_r;
  sum_t out_first_r;
  sum_t out_second_r;
  sum_t out_third_r;
  logic out_free;
  logic acc_go;

  // Only the last element of a stream needs room in the result register.
  assign out_free   = !out_valid_r || out_ch.ready;
  assign prod_ready = !prod_data.last || out_free;
  assign acc_go     = prod_valid && prod_ready;

  // Next accumulator values; r.q holds still in first-iteration mode.
  always_comb begin
    dq_nxt = add_sat(acc_dq_r, prod_data.dq[0], prod_data.dq[1], prod_data.dq[2]);
    qq_nxt = add_sat(acc_qq_r, prod_data.qq[0], prod_data.qq[1], prod_data.qq[2]);
    if (prod_data.mode) begin
      rq_nxt = acc_rq_r;
    end else begin
      rq_nxt = add_sat(acc_rq_r, prod_data.rq[0], prod_data.rq[1], prod_data.rq[2]);
    end
  end

  // Accumulators clear when the last element of a stream is taken and its sums go to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_dq_r <= '0;
      acc_rq_r <= '0;
      acc_qq_r <= '0;
    end else if (acc_go) begin
      if (prod_data.last) begin
        acc_dq_r <= '0;
        acc_rq_r <= '0;
        acc_qq_r <= '0;
      end else begin
        acc_dq_r <= dq_nxt;
        acc_rq_r <= rq_nxt;
        acc_qq_r <= qq_nxt;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_go && prod_data.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (acc_go && prod_data.last) begin
      out_first_r  <= dq_nxt;
      out_second_r <= prod_data.mode ? dq_nxt : rq_nxt;
      out_third_r  <= qq_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.first_sum  = out_first_r;
  assign out_ch.second_sum = out_second_r;
  assign out_ch.third_sum  = out_third_r;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc_go && prod_data.last |=> acc_dq_r == '0 && acc_rq_r == '0 && acc_qq_r == '0)
    else $error("accumulators not cleared after the last element");

  a_rq_hold_mode1: assert property (@(posedge clk) disable iff (!rst_n)
    acc_go && prod_data.mode && !prod_data.last |=> $stable(acc_rq_r))
    else $error("r.q accumulator changed in first-iteration mode");

  a_mode1_copy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_go && prod_data.last && prod_data.mode |=> out_second_r == out_first_r)
    else $error("first-iteration result does not repeat b.q");

endmodule

`default_nettype wire

@@ sv/cg_merged_dot_products.sv @@
// Top level of the merged dot-product pass of a conjugate gradient solver.
//
// in_ch carries one element of d (b in mode 1), q and r per transaction, all
// signed Q16.16, plus a last flag. out_ch carries one transaction per stream
// with d.q, r.q and q.q (b.q, b.q, q.q in mode 1) as saturated Q32.32 sums.
// The cfg_ APB port holds the mode register at address 0; write it only while
// the block is idle. pready is always high.
// Throughput: one element per cycle unless a last element waits on a stalled
// out_ch; it is set by the saturating accumulate loop that follows the nine
// parallel 32x32 multipliers. The sums of a stream pass through the input
// register, the product register and the result register after its last
// element is accepted.
// When out_ch stalls, elements without last keep flowing and accumulating;
// a last element waits in the product stage until the result register frees,
// and the input side then backs up stage by stage.
// Reset (rst_n low, synchronous) clears the mode, the accumulators and all
// stage valid flags.
`default_nettype none

module cg_merged_dot_products
  import cgmdp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cgmdp_in_if.sink                   in_ch,
  cgmdp_out_if.source                out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic  mode;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod_data;

  cgmdp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mode        (mode)
  );

  cgmdp_prod u_prod (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode),
    .in_ch      (in_ch),
    .prod_valid (prod_valid),
    .prod_data  (prod_data),
    .prod_ready (prod_ready)
  );

  cgmdp_acc u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_valid (prod_valid),
    .prod_data  (prod_data),
    .prod_ready (prod_ready),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
